[hdl/i2a_pkg.sv]
package i2a_pkg;

    // default width of the number
    localparam int VALUE_BITS_DEF = 64;

    // format modes
    localparam logic [1:0] MODE_DEC     = 2'd0;
    localparam logic [1:0] MODE_HEX     = 2'd1;
    localparam logic [1:0] MODE_HEX_PAD = 2'd2;
    localparam logic [1:0] MODE_BIN     = 2'd3;

    // shift unit operations
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_DABBLE = 2'd1;
    localparam logic [1:0] OP_SHIFT4 = 2'd2;
    localparam logic [1:0] OP_SHIFT1 = 2'd3;

    // ascii codes
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A    = 7'h41;

    typedef logic [1:0] op_t;

    // one digit to its upper-case ascii glyph
    function automatic logic [6:0] glyph(input logic [3:0] digit);
        logic [6:0] code;
        if (digit < 4'd10)
        begin
            code = CHAR_ZERO + {3'b000, digit};
        end
        else
        begin
            code = CHAR_A + {3'b000, digit} - 7'd10;
        end
        return code;
    endfunction

endpackage

[hdl/i2a_shift_unit.sv]
module i2a_shift_unit #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF,
    parameter int SR_BITS    = 80
) (
    input  i2a_pkg::op_t            op,
    input  logic [SR_BITS-1:0]      sr_in,
    input  logic [VALUE_BITS-1:0]   val_in,
    output logic [SR_BITS-1:0]      sr_out,
    output logic [VALUE_BITS-1:0]   val_out,
    output logic [3:0]              digit
);

    localparam int NIBBLES = SR_BITS / 4;

    logic [SR_BITS-1:0] adjusted;

    // add three to every bcd digit of five or more
    always_comb
    begin
        for (int i = 0; i < NIBBLES; i++)
        begin
            if (sr_in[i*4 +: 4] >= 4'd5)
            begin
                adjusted[i*4 +: 4] = sr_in[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adjusted[i*4 +: 4] = sr_in[i*4 +: 4];
            end
        end
    end

    // top digit as seen by the current operation
    always_comb
    begin
        if (op == i2a_pkg::OP_SHIFT1)
        begin
            digit = {3'b000, sr_in[SR_BITS-1]};
        end
        else
        begin
            digit = sr_in[SR_BITS-1 -: 4];
        end
    end

    // shift / adjust step
    always_comb
    begin
        case (op)
            i2a_pkg::OP_DABBLE:
            begin
                sr_out  = {adjusted[SR_BITS-2:0], val_in[VALUE_BITS-1]};
                val_out = {val_in[VALUE_BITS-2:0], 1'b0};
            end
            i2a_pkg::OP_SHIFT4:
            begin
                sr_out  = {sr_in[SR_BITS-5:0], 4'b0000};
                val_out = val_in;
            end
            i2a_pkg::OP_SHIFT1:
            begin
                sr_out  = {sr_in[SR_BITS-2:0], 1'b0};
                val_out = val_in;
            end
            default:
            begin
                sr_out  = sr_in;
                val_out = val_in;
            end
        endcase
    end

endmodule

[hdl/integer_to_ascii_formatter_unit.sv]
// integer to ascii formatter
// input channel: value and mode, accepted on in_valid & in_ready. mode 0 is
// decimal, 1 upper-case hex, 2 hex zero-padded to ceil(VALUE_BITS/4) digits,
// 3 binary; leading zeros are dropped except in padded hex, and zero gives '0'.
// output channel: one ascii character per emitted digit on char_code, most
// significant digit first, with last set on the final character.
// a request is taken only while idle; one item then runs through a single
// shift/adjust unit: decimal first runs VALUE_BITS double-dabble steps, then
// walks DEC_DIGITS bcd digits (20 at 64 bits); hex walks ceil(VALUE_BITS/4)
// digits and binary walks VALUE_BITS digits.
// a low out_ready with a character waiting stalls the emission of digits
// with the output register held; leading zero skips do not wait for it.
// leading zero digits are dropped at one per cycle, emitted digits go out at
// one per cycle while out_ready stays high. in_ready returns once the final
// character is loaded into the output register, so the next request overlaps
// with that character waiting there.
// reset (rst_n low, asynchronous) empties the output and returns to idle.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [63:0]           value,
    input  logic [1:0]            mode,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [6:0]            char_code,
    output logic                  last
);

    localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int HEX_BITS   = HEX_DIGITS * 4;
    localparam int SR_BITS    = DEC_DIGITS * 4;
    localparam int CNT_BITS   = $clog2(SR_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [1:0]            mode_reg, mode_next;
    logic                  started_reg, started_next;
    logic [SR_BITS-1:0]    sr_reg, sr_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    i2a_pkg::op_t          op;
    logic [SR_BITS-1:0]    sr_step;
    logic [VALUE_BITS-1:0] val_step;
    logic [3:0]            digit;
    logic [HEX_BITS-1:0]   hex_ext;
    logic                  skip;
    logic                  can_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    assign hex_ext = HEX_BITS'(value[VALUE_BITS-1:0]);

    // leading zero skip and output register space
    assign skip     = (state_reg == ST_EMIT) && (digit == 4'd0) && !started_reg
                      && (cnt_reg > CNT_BITS'(1)) && (mode_reg != i2a_pkg::MODE_HEX_PAD);
    assign can_load = !out_valid_reg || out_ready;

    // operation of the shared unit
    always_comb
    begin
        op = i2a_pkg::OP_HOLD;
        if (state_reg == ST_CONV)
        begin
            op = i2a_pkg::OP_DABBLE;
        end
        else if (state_reg == ST_EMIT && (skip || can_load))
        begin
            op = (mode_reg == i2a_pkg::MODE_BIN) ? i2a_pkg::OP_SHIFT1 : i2a_pkg::OP_SHIFT4;
        end
    end

    i2a_shift_unit #(
        .VALUE_BITS (VALUE_BITS),
        .SR_BITS    (SR_BITS)
    ) u_shift (
        .op      (op),
        .sr_in   (sr_reg),
        .val_in  (val_reg),
        .sr_out  (sr_step),
        .val_out (val_step),
        .digit   (digit)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        started_next   = started_reg;
        sr_next        = sr_step;
        val_next       = val_step;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next    = mode;
                    started_next = 1'b0;
                    val_next     = value[VALUE_BITS-1:0];
                    case (mode)
                        i2a_pkg::MODE_DEC:
                        begin
                            sr_next    = '0;
                            cnt_next   = CNT_BITS'(VALUE_BITS);
                            state_next = ST_CONV;
                        end
                        i2a_pkg::MODE_BIN:
                        begin
                            sr_next    = SR_BITS'(value[VALUE_BITS-1:0])
                                         << (SR_BITS - VALUE_BITS);
                            cnt_next   = CNT_BITS'(VALUE_BITS);
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            sr_next    = SR_BITS'(hex_ext) << (SR_BITS - HEX_BITS);
                            cnt_next   = CNT_BITS'(HEX_DIGITS);
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == CNT_BITS'(1))
                begin
                    cnt_next   = CNT_BITS'(DEC_DIGITS);
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
            end
            ST_EMIT:
            begin
                if (skip)
                begin
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
                else if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = i2a_pkg::glyph(digit);
                    last_next      = (cnt_reg == CNT_BITS'(1));
                    started_next   = 1'b1;
                    cnt_next       = cnt_reg - CNT_BITS'(1);
                    if (cnt_reg == CNT_BITS'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        sr_reg   <= sr_next;
        val_reg  <= val_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule
